// ----- hw/rtl/fsfp_pkg.sv -----
package fsfp_pkg;

  // Altitude history ring
  localparam int unsigned HISTORY_DEPTH = 16;
  localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Frame bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h22;
  localparam logic [7:0] TYPE_FLOW   = 8'h51;
  localparam logic [7:0] TYPE_ALT    = 8'h52;
  localparam logic [7:0] SUB_PRIMARY = 8'h00;
  localparam logic [7:0] SUB_SECOND  = 8'h01;

  // Flow frame checks
  localparam logic [7:0] FLOW_MIN_LEN = 8'd15;
  localparam logic [7:0] SUM_LAST_OFF = 8'd15;
  localparam logic [7:0] QUALITY_OFF  = 8'd14;
  localparam int unsigned PAY_KEEP    = 10;

  // Elapsed seconds: ms >= 256000 caps at 255, else (ms >> 3) / 125
  localparam logic [31:0] SEC_CAP_MS  = 32'd256000;
  localparam logic [15:0] RECIP125    = 16'd33555;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [7:0]  SEC_MAX     = 8'd255;

  // Result status codes
  localparam logic [2:0] STAT_FLOW    = 3'd0;
  localparam logic [2:0] STAT_ALT     = 3'd1;
  localparam logic [2:0] STAT_ALT2    = 3'd2;
  localparam logic [2:0] STAT_CSUM    = 3'd3;
  localparam logic [2:0] STAT_SUBTYPE = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] now_ms;
  } fsfp_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dx_fixed;
    logic signed [15:0] dy_fixed;
    logic [7:0]         quality;
    logic signed [31:0] dist_sum_x;
    logic signed [31:0] dist_sum_y;
    logic [15:0]        altitude;
    logic [15:0]        altitude_change;
    logic [15:0]        altitude_second;
  } fsfp_out_t;

endpackage

// ----- hw/rtl/flow_sensor_frame_parser_unit.sv -----
// Flow sensor frame parser.
// Input channel (in_valid_i / in_stall_o / in_data_i): one received byte per beat with
// its millisecond timestamp. The parser hunts for 0xAA 0x22 <free> <type> <len> frames,
// checks flow frames against their closing byte and tracks altitude frames.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result beat per closing
// byte of a flow or altitude frame; every other byte gives no beat.
// Throughput: one byte per cycle unless stalled. Frames are at least six bytes long, so
// the result path never limits the input rate while the receiver keeps up.
// A result passes the stages s1 (record, elapsed time), s2 (elapsed-seconds multiply)
// and s3 (distance multiply-accumulate), then the queue, before it shows on the output.
// The altitude history sits in a synchronous RAM; the entry that the next primary
// altitude frame compares against is read ahead every cycle.
// When the receiver stalls, results wait in a four-entry queue; the input stalls once
// the queue plus the results still in the pipeline fill it.
// Reset clears the parser state, the distance sums, the last timestamp, the history
// index and the valid bits of the history (entries never written read as zero).
module flow_sensor_frame_parser_unit
  import fsfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fsfp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fsfp_out_t out_data_o
);

  localparam logic [2:0] ST_HUNT      = 3'd0;
  localparam logic [2:0] ST_SYNC2     = 3'd1;
  localparam logic [2:0] ST_FREE      = 3'd2;
  localparam logic [2:0] ST_TYPE      = 3'd3;
  localparam logic [2:0] ST_FLOW_LEN  = 3'd4;
  localparam logic [2:0] ST_ALT_LEN   = 3'd5;
  localparam logic [2:0] ST_FLOW_BODY = 3'd6;
  localparam logic [2:0] ST_ALT_BODY  = 3'd7;

  // Parser state
  logic [2:0] state_q, state_d;
  logic [7:0] off_q, off_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] pay_q [PAY_KEEP];
  logic [7:0] pay_d [PAY_KEEP];
  logic [7:0] qual_q, qual_d;
  logic       fin_flow, fin_alt;

  logic       in_acc;
  logic [7:0] b;
  assign in_acc = in_valid_i && !in_stall_o;
  assign b      = in_data_i.data_byte;

  always_comb begin
    state_d  = state_q;
    off_d    = off_q;
    len_d    = len_q;
    sum_d    = sum_q;
    pay_d    = pay_q;
    qual_d   = qual_q;
    fin_flow = 1'b0;
    fin_alt  = 1'b0;
    case (state_q)
      ST_HUNT: begin
        if (b == SYNC_FIRST) begin
          sum_d   = b;
          state_d = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        sum_d   = sum_q + b;
        state_d = (b == SYNC_SECOND) ? ST_FREE : ST_HUNT;
      end
      ST_FREE: begin
        sum_d   = sum_q + b;
        state_d = ST_TYPE;
      end
      ST_TYPE: begin
        sum_d = sum_q + b;
        if (b == TYPE_FLOW) begin
          state_d = ST_FLOW_LEN;
        end else if (b == TYPE_ALT) begin
          state_d = ST_ALT_LEN;
        end else begin
          state_d = ST_HUNT;
        end
      end
      ST_FLOW_LEN, ST_ALT_LEN: begin
        sum_d  = sum_q + b;
        len_d  = b;
        off_d  = '0;
        qual_d = '0;
        for (int i = 0; i < PAY_KEEP; i++) begin
          pay_d[i] = '0;
        end
        state_d = (state_q == ST_FLOW_LEN) ? ST_FLOW_BODY : ST_ALT_BODY;
      end
      ST_FLOW_BODY: begin
        if (off_q == len_q) begin
          fin_flow = 1'b1;
          state_d  = ST_HUNT;
        end else begin
          for (int i = 0; i < PAY_KEEP; i++) begin
            if (off_q == 8'(i)) pay_d[i] = b;
          end
          if (off_q == QUALITY_OFF) qual_d = b;
          if (off_q < SUM_LAST_OFF) sum_d = sum_q + b;
          off_d = off_q + 8'd1;
        end
      end
      ST_ALT_BODY: begin
        // the closing byte still lands in the payload
        for (int i = 0; i < PAY_KEEP; i++) begin
          if (off_q == 8'(i)) pay_d[i] = b;
        end
        if (off_q == len_q) begin
          fin_alt = 1'b1;
          state_d = ST_HUNT;
        end else begin
          off_d = off_q + 8'd1;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      off_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
      off_q   <= off_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pay_q  <= pay_d;
      qual_q <= qual_d;
    end
  end

  // Altitude history RAM with the next-to-overwrite entry read ahead
  logic [15:0]              hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_vld_q;
  logic [HIST_AW-1:0]       idx_q, idx_inc;
  logic [15:0]              hist_rd_q;
  logic                     hist_rdv_q;
  logic                     hist_we;
  logic [15:0]              alt_new, alt_old, alt_chg;
  logic [7:0]               alt_sub;

  assign idx_inc = (idx_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : idx_q + HIST_AW'(1);
  assign alt_sub = pay_d[0];
  assign alt_new = {pay_d[1], pay_d[2]};
  assign alt_old = hist_rdv_q ? hist_rd_q : '0;
  assign alt_chg = (alt_new >= alt_old) ? alt_new - alt_old : alt_old - alt_new;
  assign hist_we = in_acc && fin_alt && (alt_sub == SUB_PRIMARY);

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[idx_q] <= alt_new;
    hist_rd_q <= hist_mem[idx_inc];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      hist_rdv_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      hist_rdv_q <= hist_vld_q[idx_inc];
      if (hist_we) begin
        hist_vld_q[idx_q] <= 1'b1;
        idx_q             <= idx_inc;
      end
    end
  end

  // Frame close: build the result and the elapsed time
  logic [31:0] last_q;
  logic [31:0] diff_ms;
  logic        flow_good;
  fsfp_out_t   rec_d;

  assign diff_ms   = in_data_i.now_ms - last_q;
  assign flow_good = (len_q >= FLOW_MIN_LEN) && (sum_q == b);

  always_comb begin
    rec_d = '0;
    if (fin_flow) begin
      if (flow_good) begin
        rec_d.status   = STAT_FLOW;
        rec_d.dx       = {pay_q[2], pay_q[3]};
        rec_d.dy       = {pay_q[4], pay_q[5]};
        rec_d.dx_fixed = {pay_q[6], pay_q[7]};
        rec_d.dy_fixed = {pay_q[8], pay_q[9]};
        rec_d.quality  = qual_q;
      end else begin
        rec_d.status = STAT_CSUM;
      end
    end else if (fin_alt) begin
      if (alt_sub == SUB_PRIMARY) begin
        rec_d.status          = STAT_ALT;
        rec_d.altitude        = alt_new;
        rec_d.altitude_change = alt_chg;
      end else if (alt_sub == SUB_SECOND) begin
        rec_d.status          = STAT_ALT2;
        rec_d.altitude_second = alt_new;
      end else begin
        rec_d.status = STAT_SUBTYPE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (in_acc && fin_flow && flow_good) begin
      last_q <= in_data_i.now_ms;
    end
  end

  // Result pipeline: seconds, then products, then accumulate
  logic               s1v_q, s2v_q, s3v_q;
  fsfp_out_t          s1_q, s2_q, s3_q;
  logic [14:0]        ms8_q;
  logic               sat_q;
  logic [30:0]        qprod;
  logic [7:0]         secs_d, secs_q;
  logic signed [24:0] px_d, py_d, px_q, py_q;

  assign qprod  = ms8_q * RECIP125;
  assign secs_d = sat_q ? SEC_MAX : qprod[RECIP_SHIFT +: 8];
  assign px_d   = $signed({1'b0, secs_q}) * s2_q.dx_fixed;
  assign py_d   = $signed({1'b0, secs_q}) * s2_q.dy_fixed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
      s3v_q <= 1'b0;
    end else begin
      s1v_q <= in_acc && (fin_flow || fin_alt);
      s2v_q <= s1v_q;
      s3v_q <= s2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= rec_d;
    ms8_q  <= diff_ms[17:3];
    sat_q  <= diff_ms >= SEC_CAP_MS;
    s2_q   <= s1_q;
    secs_q <= secs_d;
    s3_q   <= s2_q;
    px_q   <= px_d;
    py_q   <= py_d;
  end

  logic [31:0] acc_x_q, acc_y_q;
  logic [31:0] acc_x_new, acc_y_new;
  logic        push, pop, is_flow;
  fsfp_out_t   push_data;

  assign acc_x_new = acc_x_q + {{7{px_q[24]}}, px_q};
  assign acc_y_new = acc_y_q + {{7{py_q[24]}}, py_q};
  assign push      = s3v_q;
  assign is_flow   = s3_q.status == STAT_FLOW;

  always_comb begin
    push_data = s3_q;
    if (is_flow) begin
      push_data.dist_sum_x = acc_x_new;
      push_data.dist_sum_y = acc_y_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (push && is_flow) begin
      acc_x_q <= acc_x_new;
      acc_y_q <= acc_y_new;
    end
  end

  // Result queue
  fsfp_out_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q, occ;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign occ         = cnt_q + (FIFO_AW + 1)'(s1v_q) + (FIFO_AW + 1)'(s2v_q)
                     + (FIFO_AW + 1)'(s3v_q);
  // stall while every queue slot is spoken for
  assign in_stall_o  = occ >= (FIFO_AW + 1)'(FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      if (push && !pop) begin
        cnt_q <= cnt_q + (FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - (FIFO_AW + 1)'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> cnt_q < (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("results in flight exceed queue depth");

  a_sparse_results : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1v_q |=> !s1v_q)
    else $error("frame closed on consecutive beats");

  a_hist_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |=> !hist_we)
    else $error("history written on consecutive cycles");

endmodule
